FILE: rtl/core/tcpo_pkg.sv
package tcpo_pkg;

    localparam int MAX_OPTION_BYTES = 40;
    localparam int COUNT_W          = $clog2(MAX_OPTION_BYTES + 1);
    localparam int SKIP_W           = 6;

    localparam logic [SKIP_W-1:0] SKIP_MAX = '1;

    localparam logic [7:0] KIND_END     = 8'd0;
    localparam logic [7:0] KIND_NOP     = 8'd1;
    localparam logic [7:0] KIND_MSS     = 8'd2;
    localparam logic [7:0] KIND_WSCALE  = 8'd3;
    localparam logic [7:0] KIND_SACK_OK = 8'd4;

    localparam logic [7:0] MIN_OPT_LEN  = 8'd2;
    localparam logic [7:0] SCALE_ABSENT = 8'd255;

    typedef enum logic [2:0] {
        PH_KIND,
        PH_FIXED_LEN,
        PH_OTHER_LEN,
        PH_MSS_HI,
        PH_MSS_LO,
        PH_SCALE,
        PH_SKIP,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [7:0] option_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic [15:0] max_segment_size;
        logic [7:0]  window_scale;
        logic        sack_permitted;
    } result_t;

    // Held byte status and whether it moves on this cycle
    typedef struct packed {
        logic valid;
        logic advance;
    } stage_ctl_t;

endpackage

FILE: rtl/core/tcpo_ifs.sv
interface tcpo_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] option_byte;
    logic       last_byte;

    modport source (output valid, output option_byte, output last_byte, input ready);
    modport sink   (input valid, input option_byte, input last_byte, output ready);
endinterface

interface tcpo_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] max_segment_size;
    logic [7:0]  window_scale;
    logic        sack_permitted;

    modport source (output valid, output max_segment_size, output window_scale,
                    output sack_permitted, input ready);
    modport sink   (input valid, input max_segment_size, input window_scale,
                    input sack_permitted, output ready);
endinterface

FILE: rtl/core/tcp_option_decoder_top.sv
// TCP option list decoder.
// opt_in carries the option list one byte per transfer (option_byte), with
// last_byte set on the final byte. res_out carries one result per list:
// max_segment_size (0 when no MSS option), window_scale (255 when no window
// scale option) and sack_permitted.
// The last byte is taken into the input register, and its result is loaded
// into the output register once res_out is free. Throughput: one byte per
// cycle while no last byte waits on res_out; each byte is decoded
// combinationally between the input register and the parser state registers.
// A finished result sits in the output register while later bytes keep
// flowing; only a last byte waits for the output register to empty. When
// res_out stalls with a result pending and the held byte is a last byte,
// opt_in.ready drops until the result is taken.
// Bytes beyond the option area limit are ignored, but their last_byte still
// closes the list. Reset empties both registers and returns the parser to
// the start of a list, with no result pending.
module tcp_option_decoder_top
    import tcpo_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    tcpo_in_if.sink     opt_in,
    tcpo_out_if.source  res_out
);

    logic       held_valid;
    item_t      held_item;
    logic       can_load;
    logic       advance;
    stage_ctl_t ctl;
    result_t    result;

    // Advance a held byte unless it closes the list and the result slot is busy
    assign advance     = held_valid && (!held_item.last_byte || can_load);
    assign ctl.valid   = held_valid;
    assign ctl.advance = advance;

    tcpo_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .opt_in     (opt_in),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    tcpo_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .item   (held_item),
        .result (result)
    );

    // Load a result only when the last byte of a list advances
    tcpo_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance && held_item.last_byte),
        .result   (result),
        .can_load (can_load),
        .res_out  (res_out)
    );

endmodule

FILE: rtl/core/tcpo_in_stage.sv
module tcpo_in_stage
    import tcpo_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    tcpo_in_if.sink     opt_in,
    input  logic        advance,
    output logic        held_valid,
    output item_t       held_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  take;

    // Free slot, or the held byte leaves this cycle
    assign opt_in.ready = !valid_reg || advance;
    assign take         = opt_in.valid && opt_in.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.option_byte <= opt_in.option_byte;
            item_reg.last_byte   <= opt_in.last_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

FILE: rtl/core/tcpo_parser.sv
module tcpo_parser
    import tcpo_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  stage_ctl_t ctl,
    input  item_t      item,
    output result_t    result
);

    phase_t              phase_reg, phase_next;
    logic [SKIP_W-1:0]   skip_reg, skip_next;
    logic [7:0]          mss_hi_reg, mss_hi_next;
    logic [15:0]         mss_reg, mss_next;
    logic [7:0]          scale_reg, scale_next;
    logic                sack_reg, sack_next;
    logic [COUNT_W-1:0]  count_reg, count_next;

    always_comb
    begin
        logic [7:0]        b;
        logic [7:0]        len_rest;
        logic [SKIP_W-1:0] skip_dec;

        b           = item.option_byte;
        len_rest    = b - MIN_OPT_LEN;
        skip_dec    = skip_reg;
        phase_next  = phase_reg;
        skip_next   = skip_reg;
        mss_hi_next = mss_hi_reg;
        mss_next    = mss_reg;
        scale_next  = scale_reg;
        sack_next   = sack_reg;
        count_next  = count_reg;

        // Ignore bytes past the option area limit
        if (count_reg < COUNT_W'(MAX_OPTION_BYTES))
        begin
            count_next = count_reg + COUNT_W'(1);
            case (phase_reg)
                PH_KIND:
                begin
                    if (b == KIND_END)
                    begin
                        phase_next = PH_DONE;
                    end
                    else if (b == KIND_NOP)
                    begin
                        phase_next = PH_KIND;
                    end
                    else if (b == KIND_MSS || b == KIND_WSCALE)
                    begin
                        skip_next  = b[SKIP_W-1:0];
                        phase_next = PH_FIXED_LEN;
                    end
                    else if (b == KIND_SACK_OK)
                    begin
                        sack_next  = 1'b1;
                        skip_next  = SKIP_W'(1);
                        phase_next = PH_SKIP;
                    end
                    else
                    begin
                        phase_next = PH_OTHER_LEN;
                    end
                end
                PH_FIXED_LEN:
                begin
                    phase_next = (skip_reg == SKIP_W'(KIND_MSS)) ? PH_MSS_HI : PH_SCALE;
                    skip_next  = '0;
                end
                PH_OTHER_LEN:
                begin
                    if (b < MIN_OPT_LEN)
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        if (len_rest > 8'(SKIP_MAX))
                        begin
                            skip_next = SKIP_MAX;
                        end
                        else
                        begin
                            skip_next = len_rest[SKIP_W-1:0];
                        end
                        phase_next = (len_rest == 8'd0) ? PH_KIND : PH_SKIP;
                    end
                end
                PH_MSS_HI:
                begin
                    mss_hi_next = b;
                    phase_next  = PH_MSS_LO;
                end
                PH_MSS_LO:
                begin
                    mss_next   = {mss_hi_reg, b};
                    phase_next = PH_KIND;
                end
                PH_SCALE:
                begin
                    scale_next = b;
                    phase_next = PH_KIND;
                end
                PH_SKIP:
                begin
                    if (skip_reg != '0)
                    begin
                        skip_dec = skip_reg - SKIP_W'(1);
                    end
                    skip_next = skip_dec;
                    if (skip_dec == '0)
                    begin
                        phase_next = PH_KIND;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    assign result.max_segment_size = mss_next;
    assign result.window_scale     = scale_next;
    assign result.sack_permitted   = sack_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_KIND;
            skip_reg   <= '0;
            mss_hi_reg <= '0;
            mss_reg    <= '0;
            scale_reg  <= SCALE_ABSENT;
            sack_reg   <= 1'b0;
            count_reg  <= '0;
        end
        else if (ctl.valid && ctl.advance)
        begin
            if (item.last_byte)
            begin
                // Start over for the next option list
                phase_reg  <= PH_KIND;
                skip_reg   <= '0;
                mss_hi_reg <= '0;
                mss_reg    <= '0;
                scale_reg  <= SCALE_ABSENT;
                sack_reg   <= 1'b0;
                count_reg  <= '0;
            end
            else
            begin
                phase_reg  <= phase_next;
                skip_reg   <= skip_next;
                mss_hi_reg <= mss_hi_next;
                mss_reg    <= mss_next;
                scale_reg  <= scale_next;
                sack_reg   <= sack_next;
                count_reg  <= count_next;
            end
        end
    end

endmodule

FILE: rtl/core/tcpo_out_stage.sv
module tcpo_out_stage
    import tcpo_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  result_t     result,
    output logic        can_load,
    tcpo_out_if.source  res_out
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign can_load = !valid_reg || res_out.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (res_out.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign res_out.valid            = valid_reg;
    assign res_out.max_segment_size = result_reg.max_segment_size;
    assign res_out.window_scale     = result_reg.window_scale;
    assign res_out.sack_permitted   = result_reg.sack_permitted;

endmodule

FILE: rtl/core/tcpo_checker.sv
module tcpo_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic in_last,
    input logic out_valid,
    input logic out_ready
);

    // Input backpressure only comes from a stalled result
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("opt_in stalled without a pending result");

    // A new result follows a last-byte transfer via the input and output registers
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && in_last, 2))
        else $error("result without a last byte");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while stalled");

endmodule

bind tcp_option_decoder_top tcpo_checker u_tcpo_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (opt_in.valid),
    .in_ready  (opt_in.ready),
    .in_last   (opt_in.last_byte),
    .out_valid (res_out.valid),
    .out_ready (res_out.ready)
);
